[design/cwpq_pkg.sv]
package cwpq_pkg;

	localparam int unsigned QDEPTH    = 65536;
	localparam int unsigned ROWS      = 1024;
	localparam logic [16:0] QDEPTH_CNT = 17'h10000;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_FLUSH   = 2'd1;
	localparam logic [1:0] OP_DISCARD = 2'd2;

	localparam logic [2:0] MODE_NONE = 3'd1;
	localparam logic [2:0] MODE_TEXT = 3'd2;
	localparam logic [2:0] MODE_BNK0 = 3'd3;
	localparam logic [2:0] MODE_BNK3 = 3'd6;
	localparam logic [2:0] MODE_FULL = 3'd7;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_EXCL    = 2'd1;
	localparam logic [1:0] REG_DELIV   = 2'd2;
	localparam logic [1:0] REG_IOWIN   = 2'd3;

	localparam logic [15:0] LOW_PAGE_END = 16'h0200;
	localparam logic [15:0] IO_LO        = 16'hD000;
	localparam logic [15:0] IO_HI        = 16'hDFFF;
	localparam logic [9:0]  SPRPTR_LO    = 10'h3F8;
	localparam logic [15:0] TEXT_LO      = 16'h0400;
	localparam logic [15:0] TEXT_HI      = 16'h07FF;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] address;
		logic [7:0]  value;
		logic [7:0]  shadow_value;
		logic [6:0]  flush_limit;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic        out_valid;
		logic [15:0] out_address;
		logic [7:0]  out_value;
		logic        last;
		logic [16:0] pending_count;
	} result_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic q_reset;
		logic mark_rd_item;
		logic w_commit;
		logic rd_pos;
		logic rd_next;
		logic rd_head;
		logic pos_inc;
		logic shift_wr;
		logic tail_wr;
		logic f_fetch;
		logic f_commit;
		logic res_empty;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] in_op;
		logic       clr_last;
		logic       need_move;
		logic       match;
		logic       pos_last;
		logic       fl_more;
		logic       res_last;
		logic       ofree;
	} status_t;

endpackage

[design/cwpq_ctrl.sv]
module cwpq_ctrl import cwpq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output cmd_t    cmd,
	output logic    item_ready
);

	typedef enum logic [16:0] {
		S_CLR   = 17'h00001,
		S_IDLE  = 17'h00002,
		S_MRD   = 17'h00004,
		S_EVAL  = 17'h00008,
		S_SRD   = 17'h00010,
		S_SCMP  = 17'h00020,
		S_SHCHK = 17'h00040,
		S_SHWR  = 17'h00080,
		S_TAIL  = 17'h00100,
		S_FLOOP = 17'h00200,
		S_FFET  = 17'h00400,
		S_FCOM  = 17'h00800,
		S_DCLR  = 17'h01000,
		S_NOP   = 17'h02000,
		S_EMIT  = 17'h04000,
		S_SPARE0 = 17'h08000,
		S_SPARE1 = 17'h10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (st.in_valid) begin
					cmd.load = 1'b1;
					unique case (st.in_op)
						OP_WRITE: state_d = S_MRD;
						OP_FLUSH: state_d = S_FLOOP;
						OP_DISCARD: begin
							cmd.q_reset = 1'b1;
							state_d     = S_DCLR;
						end
						default: state_d = S_NOP;
					endcase
				end
			end
			S_MRD: begin
				cmd.mark_rd_item = 1'b1;
				state_d          = S_EVAL;
			end
			S_EVAL: begin
				cmd.w_commit = 1'b1;
				state_d      = st.need_move ? S_SRD : S_EMIT;
			end
			S_SRD: begin
				cmd.rd_pos = 1'b1;
				state_d    = S_SCMP;
			end
			S_SCMP: begin
				if (st.match) begin
					state_d = S_SHCHK;
				end else if (st.pos_last) begin
					state_d = S_EMIT;
				end else begin
					cmd.pos_inc = 1'b1;
					state_d     = S_SRD;
				end
			end
			S_SHCHK: begin
				if (st.pos_last) begin
					state_d = S_TAIL;
				end else begin
					cmd.rd_next = 1'b1;
					state_d     = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SHCHK;
			end
			S_TAIL: begin
				cmd.tail_wr = 1'b1;
				state_d     = S_EMIT;
			end
			S_FLOOP: begin
				if (st.fl_more) begin
					cmd.rd_head = 1'b1;
					state_d     = S_FFET;
				end else begin
					cmd.res_empty = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_FFET: begin
				cmd.f_fetch = 1'b1;
				state_d     = S_FCOM;
			end
			S_FCOM: begin
				cmd.f_commit = 1'b1;
				state_d      = S_EMIT;
			end
			S_DCLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					cmd.res_empty = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_NOP: begin
				cmd.res_empty = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				if (st.ofree) begin
					cmd.out_load = 1'b1;
					state_d      = st.res_last ? S_IDLE : S_FLOOP;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

endmodule

[design/cwpq_dp.sv]
module cwpq_dp import cwpq_pkg::*; #(
	parameter int BURST_LIMIT = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output status_t st,
	input  logic    item_valid,
	input  item_t   item_data,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data,
	input  logic    cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data
);

	// marks row: [63:0] dirty, [127:64] synced
	logic [127:0] mark_mem [ROWS];
	logic [7:0]   pend_mem [QDEPTH];
	logic [15:0]  ring_mem [QDEPTH];

	logic [2:0]  mode_q;
	logic        excl_q, deliv_q, iowin_q;
	item_t       item_q;
	logic [6:0]  lim_q, n_q;
	logic [15:0] pos_q, head_q, ent_q;
	logic [16:0] count_q;
	logic [9:0]  clr_idx_q;
	logic [127:0] mark_rd_q;
	logic [7:0]  pend_rd_q;
	logic [15:0] ring_rd_q;
	result_t     res_q, out_q;
	logic        ovalid_q;

	function automatic logic passes(input logic [15:0] a, input logic [2:0] m,
			input logic ex, input logic io);
		logic ok;
		ok = 1'b1;
		if (m == MODE_FULL) ok = 1'b0;
		if (m != MODE_NONE && ex && a < LOW_PAGE_END) ok = 1'b0;
		if (!io && a >= IO_LO && a <= IO_HI) ok = 1'b0;
		if (m == MODE_TEXT && (a < TEXT_LO || a > TEXT_HI)) ok = 1'b0;
		if (m >= MODE_BNK0 && m <= MODE_BNK3 && a[15:14] != 2'(m - MODE_BNK0)) ok = 1'b0;
		return ok;
	endfunction

	// write decision
	logic [5:0]  bi;
	logic        d_bit, s_bit, filt, drop, take, append;
	logic [16:0] cnt_w;
	assign bi     = item_q.address[5:0];
	assign d_bit  = mark_rd_q[{1'b0, bi}];
	assign s_bit  = mark_rd_q[{1'b1, bi}];
	assign filt   = passes(item_q.address, mode_q, excl_q, iowin_q);
	assign drop   = (item_q.value == item_q.shadow_value) && !d_bit && s_bit;
	assign take   = deliv_q && filt && !drop;
	assign append = take && !d_bit && (count_q < QDEPTH_CNT);
	assign cnt_w  = count_q + 17'(append);

	logic [16:0] pos_p1;
	logic [6:0]  n_p1;
	assign pos_p1 = {1'b0, pos_q} + 17'd1;
	assign n_p1   = n_q + 7'd1;

	assign st.in_valid  = item_valid;
	assign st.in_op     = item_data.operation;
	assign st.clr_last  = (clr_idx_q == 10'(ROWS - 1));
	assign st.need_move = take && d_bit && (item_q.address[9:0] >= SPRPTR_LO)
		&& (count_q >= 17'd2);
	assign st.match     = (ring_rd_q == item_q.address);
	assign st.pos_last  = (pos_p1 >= count_q);
	assign st.fl_more   = (n_q < lim_q) && (count_q != 17'd0);
	assign st.res_last  = res_q.last;
	assign st.ofree     = !ovalid_q || res_ready;

	// marks write port
	logic         mk_we;
	logic [9:0]   mk_wa;
	logic [127:0] mk_wd;
	always_comb begin
		mk_we = 1'b0;
		mk_wa = item_q.address[15:6];
		mk_wd = mark_rd_q;
		priority if (cmd.clr_step) begin
			mk_we = 1'b1;
			mk_wa = clr_idx_q;
			mk_wd = '0;
		end else if (cmd.w_commit) begin
			if (deliv_q && !filt) begin
				mk_we = 1'b1;
				mk_wd[{1'b1, bi}] = 1'b0;
			end else if (take && !d_bit) begin
				mk_we = 1'b1;
				mk_wd[{1'b0, bi}] = 1'b1;
			end
		end else if (cmd.f_commit) begin
			mk_we = 1'b1;
			mk_wa = ent_q[15:6];
			mk_wd[{1'b0, ent_q[5:0]}] = 1'b0;
			mk_wd[{1'b1, ent_q[5:0]}] = 1'b1;
		end
	end

	// ring write port
	logic        rg_we;
	logic [15:0] rg_wa, rg_wd;
	always_comb begin
		rg_we = 1'b0;
		rg_wa = head_q + count_q[15:0];
		rg_wd = item_q.address;
		priority if (cmd.w_commit) begin
			rg_we = append;
		end else if (cmd.shift_wr) begin
			rg_we = 1'b1;
			rg_wa = head_q + pos_q;
			rg_wd = ring_rd_q;
		end else if (cmd.tail_wr) begin
			rg_we = 1'b1;
			rg_wa = head_q + (count_q[15:0] - 16'd1);
		end
	end

	logic [15:0] rg_ra;
	always_comb begin
		priority if (cmd.rd_head)      rg_ra = head_q;
		else if (cmd.rd_next)          rg_ra = head_q + pos_p1[15:0];
		else                           rg_ra = head_q + pos_q;
	end

	always_ff @(posedge clk) begin
		if (mk_we) mark_mem[mk_wa] <= mk_wd;
		if (cmd.mark_rd_item) mark_rd_q <= mark_mem[item_q.address[15:6]];
		else if (cmd.f_fetch) mark_rd_q <= mark_mem[ring_rd_q[15:6]];
		if (cmd.w_commit && take) pend_mem[item_q.address] <= item_q.value;
		if (cmd.f_fetch) pend_rd_q <= pend_mem[ring_rd_q];
		if (rg_we) ring_mem[rg_wa] <= rg_wd;
		if (cmd.rd_head || cmd.rd_next || cmd.rd_pos) ring_rd_q <= ring_mem[rg_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item_data;
			lim_q  <= (item_data.flush_limit > 7'(BURST_LIMIT)) ? 7'(BURST_LIMIT)
				: item_data.flush_limit;
		end
		if (cmd.f_fetch) ent_q <= ring_rd_q;
		if (cmd.w_commit) begin
			res_q <= '{accepted: deliv_q ? take : filt, out_valid: 1'b0,
				out_address: 16'd0, out_value: 8'd0, last: 1'b1, pending_count: cnt_w};
		end else if (cmd.f_commit) begin
			res_q <= '{accepted: 1'b0, out_valid: 1'b1, out_address: ent_q,
				out_value: pend_rd_q,
				last: !((n_p1 < lim_q) && (count_q != 17'd1)),
				pending_count: count_q - 17'd1};
		end else if (cmd.res_empty) begin
			res_q <= '{accepted: 1'b0, out_valid: 1'b0, out_address: 16'd0,
				out_value: 8'd0, last: 1'b1, pending_count: count_q};
		end
		if (cmd.out_load) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 3'd0;
			excl_q    <= 1'b1;
			deliv_q   <= 1'b1;
			iowin_q   <= 1'b0;
			head_q    <= '0;
			count_q   <= '0;
			clr_idx_q <= '0;
			pos_q     <= '0;
			n_q       <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data;
					REG_EXCL:  excl_q  <= cfg_data[0];
					REG_DELIV: deliv_q <= cfg_data[0];
					REG_IOWIN: iowin_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.clr_step) clr_idx_q <= clr_idx_q + 10'd1;
			if (cmd.q_reset) begin
				head_q  <= '0;
				count_q <= '0;
			end else if (cmd.w_commit) begin
				count_q <= cnt_w;
			end else if (cmd.f_commit) begin
				head_q  <= head_q + 16'd1;
				count_q <= count_q - 17'd1;
			end
			if (cmd.load) begin
				pos_q <= '0;
				n_q   <= '0;
			end else begin
				if (cmd.pos_inc || cmd.shift_wr) pos_q <= pos_p1[15:0];
				if (cmd.f_commit) n_q <= n_p1;
			end
			if (cmd.out_load) ovalid_q <= 1'b1;
			else if (res_ready) ovalid_q <= 1'b0;
		end
	end

	assign res_valid = ovalid_q;
	assign res_data  = out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QDEPTH_CNT) else $error("ring count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.f_commit |-> count_q != 17'd0) else $error("pop from empty ring");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.f_commit |=> count_q == $past(count_q) - 17'd1) else $error("pop count slip");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!ovalid_q || res_ready)) else $error("result overwritten");
`endif

endmodule

[design/coalescing_write_post_queue_unit.sv]
// A write reads its mark row, commits its decision and emits its result; a
// sprite-pointer rewrite first walks ring entries (search and shift through the
// single ring read port). A flush pops and emits one entry at a time.
// One item is in flight at a time; the result register lets the next item enter.
// Reset: asynchronous, active low; afterwards a pass clears all 1024 dirty and synced
// mark rows, during which no item is accepted (config writes still taken).
module coalescing_write_post_queue_unit import cwpq_pkg::*; #(
	parameter int BURST_LIMIT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item_data,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data
);

	cmd_t    cmd;
	status_t st;

	cwpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.st         (st),
		.cmd        (cmd),
		.item_ready (item_ready)
	);

	cwpq_dp #(.BURST_LIMIT(BURST_LIMIT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.item_valid (item_valid),
		.item_data  (item_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule
